// File: src/npal_pkg.sv
`timescale 1ns / 1ps

package npal_pkg;

    // Default sizing
    localparam int TABLE_ROWS_DEF  = 256;
    localparam int COORD_WIDTH_DEF = 16;

    // Row layout: columns 0..2 are x, y, z; the angles follow
    localparam int NUM_ANGLES      = 10;
    localparam int COL_ANGLE_FIRST = 3;
    localparam int COL_LAST        = COL_ANGLE_FIRST + NUM_ANGLES - 1;
    localparam int COL_Z           = 2;

    // Input kinds carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register map (index taken from paddr[2])
    localparam logic REG_ENTRY_COUNT = 1'b0;

    // Tag that travels with each coordinate through the distance unit
    typedef struct packed {
        logic valid;
        logic first;   // x coordinate of a row
        logic last;    // z coordinate of a row
        logic tail;    // z coordinate of the final row of the scan
    } t_pipe_ctl;

endpackage

// File: src/npal_dist_unit.sv
`timescale 1ns / 1ps

module npal_dist_unit
    import npal_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ROW_W       = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_pipe_ctl                     i_ctl,
    input  logic [ROW_W-1:0]              i_row,
    input  logic signed [COORD_WIDTH-1:0] i_coord,
    input  logic signed [COORD_WIDTH-1:0] i_qcoord,
    output logic                          o_done,
    output logic [ROW_W-1:0]              o_best_row
);

    localparam int SQ_W   = 2 * COORD_WIDTH + 1;
    localparam int DIST_W = 2 * COORD_WIDTH + 2;

    t_pipe_ctl                    r_ctl2, r_ctl3;
    logic [ROW_W-1:0]             r_row2, r_row3;
    logic signed [COORD_WIDTH:0]  r_diff;
    logic [SQ_W-1:0]              r_sq;
    logic [DIST_W-1:0]            r_acc;
    logic [DIST_W-1:0]            r_best_d;
    logic [ROW_W-1:0]             r_best_row;
    logic                         r_have;
    logic                         r_done;

    logic signed [DIST_W-1:0]     w_prod;
    logic [DIST_W-1:0]            w_sum;
    logic                         w_better;

    assign w_prod   = r_diff * r_diff;
    assign w_sum    = (r_ctl3.first ? '0 : r_acc) + DIST_W'(r_sq);
    // strict compare keeps the lowest row on a tie
    assign w_better = !r_have || (w_sum < r_best_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_have <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // difference stage
            r_ctl2 <= i_ctl;
            r_row2 <= i_row;
            r_diff <= (COORD_WIDTH+1)'(i_coord) - (COORD_WIDTH+1)'(i_qcoord);
            // square stage
            r_ctl3 <= r_ctl2;
            r_row3 <= r_row2;
            r_sq   <= w_prod[SQ_W-1:0];
            // accumulate and compare stage
            r_done <= 1'b0;
            if (r_ctl3.valid) begin
                r_acc <= w_sum;
                if (r_ctl3.last) begin
                    if (w_better) begin
                        r_best_d   <= w_sum;
                        r_best_row <= r_row3;
                    end
                    r_have <= !r_ctl3.tail;
                    r_done <= r_ctl3.tail;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_best_row = r_best_row;

    // z always follows a y sample in the cycle before
    a_coord_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl3.valid && r_ctl3.last |->
            $past(r_ctl3.valid && !r_ctl3.first && !r_ctl3.last))
        else $error("distance unit: z sample without preceding y sample");

    // completion comes only with the final row of a scan, so it cannot repeat at once
    a_done_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("distance unit: back-to-back completion");

    // best distance only shrinks within a scan
    a_best_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have && $past(r_have) |-> r_best_d <= $past(r_best_d))
        else $error("distance unit: best distance grew during a scan");

endmodule

// File: src/nearest_point_angle_lookup.sv
`timescale 1ns / 1ps
// Nearest-point angle lookup.
// Slave stream (s_axis_*): one beat is either a table write (tuser = 0) that
// stores one 16-bit word of a row, or a query (tuser = 1) that brings a point.
// Master stream (m_axis_*): one beat per query, none per write. tuser is the
// found flag; tdata carries the nearest row index and its ten angles.
// APB port: register entry_count at address 0 sets how many rows a query
// scans; values above the table size saturate. pready is always high.
// Writes: the block stays ready after a write, so writes can follow back to back.
// A query raises m_axis_tvalid once its scan, drain and angle fetch are done
// (scan, drain and fetch are skipped when the table is empty), and the next beat
// can go in once the result is loaded: the single subtract/square/accumulate
// unit handles one coordinate per cycle, its pipeline drains, then ten angle
// reads go through the one read port of the angle memory. s_axis_tready is
// low for the whole query.
// The result sits in an output register; a stalled receiver holds it there
// while writes keep flowing, and a further query waits only at its final load.
// Reset clears the control state and entry_count; table memories keep their
// contents and every row word must be written before a query reads it.
module nearest_point_angle_lookup
    import npal_pkg::*;
#(
    parameter int TABLE_ROWS  = TABLE_ROWS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input beats
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // row[7:0], column[11:8], word_value[27:12], query_x[43:28],
    // query_y[59:44], query_z[75:60], zero[79:76]
    input  logic [79:0]  s_axis_tdata,
    // operation[0]
    input  logic         s_axis_tuser,
    // result beats
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // nearest_row[7:0], angle_1[23:8], angle_2[39:24], ... angle_10[167:152]
    output logic [167:0] m_axis_tdata,
    // found[0]
    output logic         m_axis_tuser
);

    localparam int ROW_W     = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int CNT_W     = $clog2(TABLE_ROWS + 1);
    localparam int PT_DEPTH  = TABLE_ROWS * 4;
    localparam int PT_AW     = ROW_W + 2;
    localparam int ANG_DEPTH = TABLE_ROWS * NUM_ANGLES;
    localparam int ANG_AW    = $clog2(ANG_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_FWAIT,
        S_LOAD
    } t_state;

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic [7:0]                   w_in_row;
    logic [3:0]                   w_in_col;
    logic signed [15:0]           w_in_word;
    logic signed [15:0]           w_in_qx, w_in_qy, w_in_qz;
    logic signed [COORD_WIDTH-1:0] w_word_c;
    logic                         w_s_beat;
    logic                         w_wr_ok;
    logic [ROW_W-1:0]             w_wr_row;
    logic                         w_pt_we, w_ang_we;
    logic [PT_AW-1:0]             w_pt_waddr, w_pt_raddr;
    logic [ANG_AW-1:0]            w_ang_waddr, w_ang_raddr;
    logic [CNT_W-1:0]             w_n;
    logic                         w_cfg_wr;

    assign w_in_row  = s_axis_tdata[7:0];
    assign w_in_col  = s_axis_tdata[11:8];
    assign w_in_word = s_axis_tdata[27:12];
    assign w_in_qx   = s_axis_tdata[43:28];
    assign w_in_qy   = s_axis_tdata[59:44];
    assign w_in_qz   = s_axis_tdata[75:60];

    // wrap the stored word to the coordinate width
    assign w_word_c  = COORD_WIDTH'(w_in_word);

    assign w_s_beat  = s_axis_tvalid && s_axis_tready;
    // drop writes outside the table or beyond the last column
    assign w_wr_ok   = w_s_beat && (s_axis_tuser == OP_WRITE)
                       && ({24'd0, w_in_row} < 32'(TABLE_ROWS))
                       && (32'(w_in_col) <= 32'(COL_LAST));
    assign w_wr_row  = ROW_W'(w_in_row);
    assign w_pt_we   = w_wr_ok && (32'(w_in_col) <= 32'(COL_Z));
    assign w_ang_we  = w_wr_ok && (32'(w_in_col) >= 32'(COL_ANGLE_FIRST));
    assign w_pt_waddr  = {w_wr_row, w_in_col[1:0]};
    assign w_ang_waddr = ANG_AW'(w_wr_row) * ANG_AW'(NUM_ANGLES)
                         + ANG_AW'(w_in_col - 4'(COL_ANGLE_FIRST));

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [8:0] r_entry_count;

    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_ENTRY_COUNT) ? 32'(r_entry_count) : 32'd0;

    // saturate the row count to the table size
    assign w_n = (32'(r_entry_count) > 32'(TABLE_ROWS)) ? CNT_W'(TABLE_ROWS)
                                                        : CNT_W'(r_entry_count);

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------
    t_state                        r_state;
    logic [ROW_W-1:0]              r_row;
    logic [1:0]                    r_col;
    logic [CNT_W-1:0]              r_n;
    logic signed [COORD_WIDTH-1:0] r_qx, r_qy, r_qz;
    t_pipe_ctl                     r_ptag;
    logic [ROW_W-1:0]              r_ptag_row;
    logic [ROW_W-1:0]              r_best_row;
    logic                          r_found;
    logic [ANG_AW-1:0]             r_ang_base;
    logic [3:0]                    r_k;
    logic                          r_atag_v;
    logic [3:0]                    r_atag_k;
    logic signed [15:0]            r_ang [NUM_ANGLES];
    logic                          r_m_tvalid;
    logic [167:0]                  r_m_tdata;
    logic                          r_m_tuser;

    // table memories
    logic signed [COORD_WIDTH-1:0] r_pt_mem [PT_DEPTH];
    logic signed [COORD_WIDTH-1:0] r_pt_rd;
    logic signed [15:0]            r_ang_mem [ANG_DEPTH];
    logic signed [15:0]            r_ang_rd;

    logic                          w_last_col;
    logic                          w_last_row;
    logic signed [COORD_WIDTH-1:0] w_qcoord;
    logic                          w_done;
    logic [ROW_W-1:0]              w_best_row;

    assign w_last_col  = (32'(r_col) == 32'(COL_Z));
    assign w_last_row  = ((CNT_W'(r_row) + CNT_W'(1)) == r_n);
    assign w_pt_raddr  = {r_row, r_col};
    assign w_ang_raddr = r_ang_base + ANG_AW'(r_k);

    // pick the query coordinate that matches the sample leaving the memory
    assign w_qcoord = r_ptag.first ? r_qx : (r_ptag.last ? r_qz : r_qy);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    always_ff @(posedge i_clk) begin
        if (w_pt_we) begin
            r_pt_mem[w_pt_waddr] <= w_word_c;
        end
        r_pt_rd <= r_pt_mem[w_pt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_ang_we) begin
            r_ang_mem[w_ang_waddr] <= w_in_word;
        end
        r_ang_rd <= r_ang_mem[w_ang_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= 9'd0;
            r_ptag        <= '0;
            r_atag_v      <= 1'b0;
            r_m_tvalid    <= 1'b0;
        end else begin
            if (w_cfg_wr && (paddr[2] == REG_ENTRY_COUNT)) begin
                r_entry_count <= pwdata[8:0];
            end

            r_ptag   <= '0;
            r_atag_v <= 1'b0;

            // drop the result once the receiver takes it
            if (r_m_tvalid && m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_s_beat && (s_axis_tuser == OP_QUERY)) begin
                        r_qx       <= COORD_WIDTH'(w_in_qx);
                        r_qy       <= COORD_WIDTH'(w_in_qy);
                        r_qz       <= COORD_WIDTH'(w_in_qz);
                        r_n        <= w_n;
                        r_row      <= '0;
                        r_col      <= '0;
                        r_found    <= 1'b0;
                        r_best_row <= '0;
                        for (int k = 0; k < NUM_ANGLES; k++) begin
                            r_ang[k] <= '0;
                        end
                        // an empty table goes straight to the result
                        r_state <= (w_n == '0) ? S_LOAD : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue one coordinate read a cycle, x then y then z
                    r_ptag.valid <= 1'b1;
                    r_ptag.first <= (r_col == 2'd0);
                    r_ptag.last  <= w_last_col;
                    r_ptag.tail  <= w_last_col && w_last_row;
                    r_ptag_row   <= r_row;
                    if (w_last_col) begin
                        r_col <= '0;
                        r_row <= r_row + ROW_W'(1);
                        if (w_last_row) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_col <= r_col + 2'd1;
                    end
                end
                S_DRAIN: begin
                    // wait for the final distance to clear the unit
                    if (w_done) begin
                        r_found    <= 1'b1;
                        r_best_row <= w_best_row;
                        r_ang_base <= ANG_AW'(w_best_row) * ANG_AW'(NUM_ANGLES);
                        r_k        <= '0;
                        r_state    <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_atag_v <= 1'b1;
                    r_atag_k <= r_k;
                    if (32'(r_k) == NUM_ANGLES - 1) begin
                        r_state <= S_FWAIT;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_FWAIT: begin
                    // last angle lands in the staging row this cycle
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    // hold until the output register is free
                    if (!r_m_tvalid || m_axis_tready) begin
                        r_m_tvalid       <= 1'b1;
                        r_m_tuser        <= r_found;
                        r_m_tdata[7:0]   <= 8'(r_best_row);
                        for (int k = 0; k < NUM_ANGLES; k++) begin
                            r_m_tdata[8 + 16*k +: 16] <= r_ang[k];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (r_atag_v) begin
                r_ang[r_atag_k] <= r_ang_rd;
            end
        end
    end

    npal_dist_unit #(
        .COORD_WIDTH (COORD_WIDTH),
        .ROW_W       (ROW_W)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_ptag),
        .i_row      (r_ptag_row),
        .i_coord    (r_pt_rd),
        .i_qcoord   (w_qcoord),
        .o_done     (w_done),
        .o_best_row (w_best_row)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> CNT_W'(r_row) < r_n)
        else $error("scan row counter passed the row count");

    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == S_DRAIN)
        else $error("distance unit finished outside the drain phase");

    a_angle_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_atag_v |-> r_atag_k < 4'(NUM_ANGLES))
        else $error("angle read tag out of range");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("empty-table result carries non-zero data");

endmodule
